// File: hw/rtl/hsq_pkg.sv
// ----------------------------------------------------------------------------
// hsq_pkg
// Shared types, codes and helpers for the stepper homing sequencer.
// ----------------------------------------------------------------------------
package hsq_pkg;

	// Sequencer phases.
	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_BACKOFF = 3'd1,
		PH_SEEK    = 3'd2,
		PH_OVER    = 3'd3,
		PH_RETURN  = 3'd4
	} phase_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_PULSE_PERIOD = 2'd0,
		REG_MIDDLE_STEPS = 2'd1,
		REG_BASE_STEPS   = 2'd2,
		REG_MAX_STEPS    = 2'd3
	} reg_idx_t;

	localparam int CFG_DATA_W = 32;

	// Register reset values.
	localparam logic [19:0] PULSE_PERIOD_RST = 20'd1000;
	localparam logic [15:0] MIDDLE_STEPS_RST = 16'd100;
	localparam logic [15:0] BASE_STEPS_RST   = 16'd0;
	localparam logic [31:0] MAX_STEPS_RST    = 32'd100000;

	// One tick item.
	typedef struct packed {
		logic start_req;
		logic limit_switch;
		logic abort;
	} hsq_in_t;

	// One result item.
	typedef struct packed {
		logic        step_pulse;
		logic        toward_switch;
		logic        busy_res;
		logic        done_res;
		logic        failed;
		logic [15:0] position;
	} hsq_out_t;

	// Current register settings.
	typedef struct packed {
		logic [19:0] pulse_period;
		logic [15:0] middle_steps;
		logic [15:0] base_steps;
		logic [31:0] max_steps;
	} hsq_cfg_t;

	// Sequencer state carried from tick to tick.
	typedef struct packed {
		phase_t      phase;
		logic [19:0] half_timer;
		logic        pulse_level;
		logic [31:0] step_count;
		logic [15:0] home_position;
		logic        fail_flag;
	} hsq_state_t;

	// Half of the pulse period, never less than one tick.
	function automatic logic [19:0] half_len(input logic [19:0] period);
		logic [19:0] h;
		h = {1'b0, period[19:1]};
		return (h != 20'd0) ? h : 20'd1;
	endfunction

endpackage

// File: hw/rtl/hsq_cfg.sv
// ----------------------------------------------------------------------------
// hsq_cfg
// Configuration register file with a plain write port.
// ----------------------------------------------------------------------------
module hsq_cfg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [1:0]            cfg_index,
	input  logic [31:0]           cfg_data,
	output hsq_pkg::hsq_cfg_t     cfg
);
	import hsq_pkg::*;

	hsq_cfg_t cfg_q;

	// Registers take the write data at once; all but max_steps keep only their low bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_period <= PULSE_PERIOD_RST;
			cfg_q.middle_steps <= MIDDLE_STEPS_RST;
			cfg_q.base_steps   <= BASE_STEPS_RST;
			cfg_q.max_steps    <= MAX_STEPS_RST;
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_PULSE_PERIOD: cfg_q.pulse_period <= cfg_data[19:0];
				REG_MIDDLE_STEPS: cfg_q.middle_steps <= cfg_data[15:0];
				REG_BASE_STEPS:   cfg_q.base_steps   <= cfg_data[15:0];
				REG_MAX_STEPS:    cfg_q.max_steps    <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hw/rtl/hsq_step.sv
// ----------------------------------------------------------------------------
// hsq_step
// Next-state and result logic for one tick of the homing sequence.
// ----------------------------------------------------------------------------
module hsq_step (
	input  hsq_pkg::hsq_state_t st,
	input  hsq_pkg::hsq_cfg_t   cfg,
	input  hsq_pkg::hsq_in_t    item,
	output hsq_pkg::hsq_state_t st_next,
	output hsq_pkg::hsq_out_t   res
);
	import hsq_pkg::*;

	hsq_state_t n;
	logic       done;
	logic       dir;
	logic       level;

	// The phase decisions chain within one tick: a phase with nothing left
	// to do hands over to the next one on the same tick.
	always_comb begin
		n     = st;
		done  = 1'b0;
		dir   = 1'b0;
		level = 1'b0;

		if (n.phase == PH_IDLE) begin
			// Start only picks backoff or seek; no pulse yet.
			if (item.start_req) begin
				n.fail_flag     = 1'b0;
				n.step_count    = 32'd0;
				n.home_position = 16'd0;
				n.half_timer    = 20'd0;
				n.pulse_level   = 1'b0;
				n.phase         = (item.limit_switch && cfg.middle_steps != 16'd0)
					? PH_BACKOFF : PH_SEEK;
				dir             = (n.phase == PH_SEEK);
			end
		end else begin
			// Decision point between pulses.
			if (n.half_timer == 20'd0) begin
				if (n.phase == PH_BACKOFF) begin
					if (n.step_count < {16'd0, cfg.middle_steps}) begin
						n.step_count  = n.step_count + 32'd1;
						n.pulse_level = 1'b1;
						n.half_timer  = half_len(cfg.pulse_period);
					end else begin
						n.phase      = PH_SEEK;
						n.step_count = 32'd0;
					end
				end
				if (n.phase == PH_SEEK && n.half_timer == 20'd0) begin
					if (!item.limit_switch) begin
						if (n.step_count != '1) begin
							n.step_count = n.step_count + 32'd1;
						end
						n.pulse_level = 1'b1;
						n.half_timer  = half_len(cfg.pulse_period);
					end else begin
						n.phase      = PH_OVER;
						n.step_count = 32'd0;
					end
				end
				if (n.phase == PH_OVER && n.half_timer == 20'd0) begin
					if (n.step_count < {16'd0, cfg.base_steps}) begin
						n.step_count  = n.step_count + 32'd1;
						n.pulse_level = 1'b1;
						n.half_timer  = half_len(cfg.pulse_period);
					end else begin
						n.phase         = PH_RETURN;
						n.home_position = 16'd0;
					end
				end
				if (n.phase == PH_RETURN && n.half_timer == 20'd0) begin
					if (n.home_position < cfg.middle_steps) begin
						n.pulse_level = 1'b1;
						n.half_timer  = half_len(cfg.pulse_period);
					end else begin
						n.phase = PH_IDLE;
						done    = 1'b1;
					end
				end
			end

			dir   = (n.phase == PH_SEEK || n.phase == PH_OVER);
			level = n.pulse_level;

			// Half-period countdown; the end of a high half closes the pulse.
			if (n.half_timer != 20'd0) begin
				n.half_timer = n.half_timer - 20'd1;
				if (n.half_timer == 20'd0) begin
					if (n.pulse_level) begin
						n.pulse_level = 1'b0;
						n.half_timer  = half_len(cfg.pulse_period);
					end else if (n.phase == PH_SEEK) begin
						if (n.step_count > cfg.max_steps || item.abort) begin
							n.fail_flag = 1'b1;
							n.phase     = PH_IDLE;
							done        = 1'b1;
						end
					end else if (n.phase == PH_RETURN) begin
						n.home_position = n.home_position + 16'd1;
					end
				end
			end

			if (n.phase == PH_IDLE && done && n.fail_flag) begin
				dir = 1'b1;
			end
		end
	end

	assign st_next = n;

	// Result fields for this tick.
	always_comb begin
		res.step_pulse    = level;
		res.toward_switch = dir;
		res.busy_res      = (n.phase != PH_IDLE);
		res.done_res      = done;
		res.failed        = n.fail_flag;
		res.position      = n.home_position;
	end

endmodule

// File: hw/rtl/stepper_homing_sequencer_core.sv
// ----------------------------------------------------------------------------
// stepper_homing_sequencer_core
// Stepper motor homing sequencer driven by one tick item per microsecond.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one tick item (start_req, limit_switch, abort)
//   per microsecond; the output channel returns exactly one result item per
//   tick item: step pin level, direction, busy, done, failed and position.
//   Both channels use valid/stall; an item moves when valid is high and
//   stall is low.
//   The result item appears on the output after its tick item is accepted:
//   the item waits in the input register, then the sequencer logic loads
//   the output register. One item is taken every cycle unless the receiver
//   stalls; the sequencer state advances once per tick item. When the
//   receiver stalls, the output register holds its result, the input
//   register keeps its item, and the input channel stalls in turn. Reset
//   clears the pipeline valids, returns the sequencer to idle and loads the
//   register defaults (period 1000, middle 100, base 0, max 100000). The
//   user keeps cfg port register writes to idle; the block does not check.
// ----------------------------------------------------------------------------
module stepper_homing_sequencer_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  hsq_pkg::hsq_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output hsq_pkg::hsq_out_t out_data,
	input  logic              cfg_wr_en,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data
);
	import hsq_pkg::*;

	hsq_cfg_t   cfg;
	hsq_in_t    in_s1;
	logic       in_vld_s1;
	hsq_out_t   out_s2;
	logic       out_vld_s2;
	hsq_state_t state_q;
	hsq_state_t state_next;
	hsq_out_t   res;
	logic       adv;

	hsq_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hsq_step u_step (
		.st      (state_q),
		.cfg     (cfg),
		.item    (in_s1),
		.st_next (state_next),
		.res     (res)
	);

	// The held item is processed when the output register is free or drains.
	assign adv      = in_vld_s1 && (!out_vld_s2 || !out_stall);
	assign in_stall = in_vld_s1 && !adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			in_vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			in_s1 <= in_data;
		end
	end

	// Sequencer state advances once per processed item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase         <= PH_IDLE;
			state_q.half_timer    <= 20'd0;
			state_q.pulse_level   <= 1'b0;
			state_q.step_count    <= 32'd0;
			state_q.home_position <= 16'd0;
			state_q.fail_flag     <= 1'b0;
		end else if (adv) begin
			state_q <= state_next;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_s2 <= 1'b0;
		end else if (adv) begin
			out_vld_s2 <= 1'b1;
		end else if (!out_stall) begin
			out_vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_s2 <= res;
		end
	end

	assign out_valid = out_vld_s2;
	assign out_data  = out_s2;

endmodule

// File: hw/rtl/hsq_chk.sv
// ----------------------------------------------------------------------------
// hsq_chk
// Port-level checks for the stepper homing sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module hsq_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input hsq_pkg::hsq_out_t out_data
);
	import hsq_pkg::*;

	// A stalled result stays valid and unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// The tick that ends a run never reports the run as still busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.done_res |-> !out_data.busy_res)
		else $error("done reported while busy");

	// While idle the step and direction pins rest low.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.busy_res && !out_data.done_res
		|-> !out_data.step_pulse && !out_data.toward_switch)
		else $error("pins active while idle");

	// A run that ends without failure has reached the return phase; on its final
	// tick the direction pin points away from the switch and no step pulse is high.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.done_res && !out_data.failed
		|-> !out_data.toward_switch && !out_data.step_pulse)
		else $error("bad pins on successful finish");

endmodule

bind stepper_homing_sequencer_core hsq_chk u_hsq_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
